### design/i2cbm_pkg.sv
`timescale 1ns / 1ps

package i2cbm_pkg;

  localparam int TX_DEPTH = 16;
  localparam int TX_IDX_W = $clog2(TX_DEPTH);

  localparam logic [2:0] ADDR_TOP_BIT = 3'd6;
  localparam logic [2:0] BYTE_TOP_BIT = 3'd7;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  localparam logic [1:0] ST_SET_SDA  = 2'd0;
  localparam logic [1:0] ST_REL_SCL  = 2'd1;
  localparam logic [1:0] ST_SAMPLE   = 2'd2;
  localparam logic [1:0] ST_ADVANCE  = 2'd3;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_START = 9'b000000010,
    PH_ADDR  = 9'b000000100,
    PH_RW    = 9'b000001000,
    PH_RACK  = 9'b000010000,
    PH_WACK  = 9'b000100000,
    PH_RDATA = 9'b001000000,
    PH_WDATA = 9'b010000000,
    PH_STOP  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       scl_in;
    logic       sda_in;
    logic [6:0] dev_addr;
    logic       read_op;
    logic [4:0] tx_len;
    logic [7:0] rx_len;
    logic [3:0] tx_index;
    logic [7:0] tx_data;
  } item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       busy_res;
    logic       ack_error;
    logic       done_res;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [TX_IDX_W-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

### design/i2cbm_tx_store.sv
`timescale 1ns / 1ps

module i2cbm_tx_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/i2cbm_core.sv
`timescale 1ns / 1ps

module i2cbm_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  i2cbm_pkg::item_t               item,
  input  logic [7:0]                     store_rdata,
  output logic [i2cbm_pkg::TX_IDX_W-1:0] store_raddr,
  output i2cbm_pkg::store_wr_t           store_wr,
  output i2cbm_pkg::result_t             res
);

  i2cbm_pkg::phase_t phase, phase_next;
  logic [1:0] sub_tick, sub_tick_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [6:0] target_addr, target_addr_next;
  logic       addr_read_bit, addr_read_bit_next;
  logic [4:0] tx_remaining, tx_remaining_next;
  logic [4:0] tx_position, tx_position_next;
  logic [7:0] rx_remaining, rx_remaining_next;
  logic       stretch_seen, stretch_seen_next;
  logic       ack_sample, ack_sample_next;
  logic       error_flag, error_flag_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       rx_valid, done;
  logic       idle;
  logic [7:0] addr_ext;
  logic [4:0] rx_start;
  logic [4:0] tx_start;

  assign idle        = (phase == i2cbm_pkg::PH_IDLE);
  assign addr_ext    = {1'b0, target_addr};
  assign store_raddr = i2cbm_pkg::TX_IDX_W'(tx_position);
  assign tx_start    = (6'(item.tx_len) > 6'(i2cbm_pkg::TX_DEPTH)) ?
                       5'(i2cbm_pkg::TX_DEPTH) : item.tx_len;
  assign rx_start    = 5'(0);

  always_comb begin
    phase_next         = phase;
    sub_tick_next      = sub_tick;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    target_addr_next   = target_addr;
    addr_read_bit_next = addr_read_bit;
    tx_remaining_next  = tx_remaining;
    tx_position_next   = tx_position;
    rx_remaining_next  = rx_remaining;
    stretch_seen_next  = stretch_seen;
    ack_sample_next    = ack_sample;
    error_flag_next    = error_flag;
    scl_drive_next     = scl_drive;
    sda_drive_next     = sda_drive;
    rx_valid           = 1'b0;
    done               = 1'b0;
    store_wr.en        = 1'b0;
    store_wr.addr      = i2cbm_pkg::TX_IDX_W'(item.tx_index);
    store_wr.data      = item.tx_data;

    case (item.req_type)
      i2cbm_pkg::REQ_START: begin
        if (idle) begin
          target_addr_next   = item.dev_addr;
          tx_remaining_next  = tx_start;
          tx_position_next   = rx_start;
          rx_remaining_next  = item.read_op ? item.rx_len : 8'd0;
          addr_read_bit_next = (item.read_op && item.rx_len != 8'd0 &&
                                tx_start == 5'd0);
          ack_sample_next    = 1'b1;
          error_flag_next    = 1'b0;
          stretch_seen_next  = 1'b0;
          sub_tick_next      = i2cbm_pkg::ST_SET_SDA;
          phase_next         = i2cbm_pkg::PH_START;
        end
      end
      i2cbm_pkg::REQ_LOAD: begin
        store_wr.en = idle && (9'(item.tx_index) < 9'(i2cbm_pkg::TX_DEPTH));
      end
      i2cbm_pkg::REQ_TICK: begin
        if (!idle) begin
          case (sub_tick)
            i2cbm_pkg::ST_SET_SDA: begin
              sub_tick_next = i2cbm_pkg::ST_REL_SCL;
              case (phase)
                i2cbm_pkg::PH_START, i2cbm_pkg::PH_RACK, i2cbm_pkg::PH_RDATA:
                  sda_drive_next = 1'b0;
                i2cbm_pkg::PH_ADDR:  sda_drive_next = !addr_ext[bit_count];
                i2cbm_pkg::PH_RW:    sda_drive_next = !addr_read_bit;
                i2cbm_pkg::PH_WACK:  sda_drive_next = (rx_remaining != 8'd0);
                i2cbm_pkg::PH_WDATA: sda_drive_next = !shift_byte[bit_count];
                i2cbm_pkg::PH_STOP:  sda_drive_next = 1'b1;
                default: ;
              endcase
            end
            i2cbm_pkg::ST_REL_SCL: begin
              scl_drive_next = 1'b0;
              sub_tick_next  = i2cbm_pkg::ST_SAMPLE;
            end
            i2cbm_pkg::ST_SAMPLE: begin
              sub_tick_next = i2cbm_pkg::ST_ADVANCE;
              if (!item.scl_in) begin
                stretch_seen_next = 1'b1;
              end else begin
                case (phase)
                  i2cbm_pkg::PH_START: sda_drive_next = 1'b1;
                  i2cbm_pkg::PH_RACK:  ack_sample_next = item.sda_in;
                  i2cbm_pkg::PH_RDATA:
                    shift_byte_next = shift_byte | (8'(item.sda_in) << bit_count);
                  i2cbm_pkg::PH_STOP:  sda_drive_next = 1'b0;
                  default: ;
                endcase
              end
            end
            default: begin
              sub_tick_next = i2cbm_pkg::ST_SET_SDA;
              if (stretch_seen) begin
                stretch_seen_next = 1'b0;
              end else begin
                if (phase != i2cbm_pkg::PH_STOP) begin
                  scl_drive_next = 1'b1;
                end
                case (phase)
                  i2cbm_pkg::PH_START: begin
                    bit_count_next = i2cbm_pkg::ADDR_TOP_BIT;
                    phase_next     = i2cbm_pkg::PH_ADDR;
                  end
                  i2cbm_pkg::PH_ADDR: begin
                    if (bit_count != 3'd0) begin
                      bit_count_next = bit_count - 3'd1;
                    end else begin
                      phase_next = i2cbm_pkg::PH_RW;
                    end
                  end
                  i2cbm_pkg::PH_RW: phase_next = i2cbm_pkg::PH_RACK;
                  i2cbm_pkg::PH_RACK: begin
                    if (ack_sample) begin
                      error_flag_next = 1'b1;
                      phase_next      = i2cbm_pkg::PH_STOP;
                    end else if (tx_remaining != 5'd0) begin
                      bit_count_next  = i2cbm_pkg::BYTE_TOP_BIT;
                      shift_byte_next = (6'(tx_position) < 6'(i2cbm_pkg::TX_DEPTH)) ?
                                        store_rdata : 8'd0;
                      phase_next      = i2cbm_pkg::PH_WDATA;
                    end else if (rx_remaining == 8'd0) begin
                      phase_next = i2cbm_pkg::PH_STOP;
                    end else if (!addr_read_bit) begin
                      addr_read_bit_next = 1'b1;
                      phase_next         = i2cbm_pkg::PH_START;
                    end else begin
                      bit_count_next  = i2cbm_pkg::BYTE_TOP_BIT;
                      shift_byte_next = 8'd0;
                      phase_next      = i2cbm_pkg::PH_RDATA;
                    end
                  end
                  i2cbm_pkg::PH_WACK: begin
                    if (rx_remaining == 8'd0) begin
                      phase_next = i2cbm_pkg::PH_STOP;
                    end else begin
                      bit_count_next  = i2cbm_pkg::BYTE_TOP_BIT;
                      shift_byte_next = 8'd0;
                      phase_next      = i2cbm_pkg::PH_RDATA;
                    end
                  end
                  i2cbm_pkg::PH_RDATA: begin
                    if (bit_count != 3'd0) begin
                      bit_count_next = bit_count - 3'd1;
                    end else begin
                      rx_valid          = 1'b1;
                      rx_remaining_next = rx_remaining - 8'd1;
                      phase_next        = i2cbm_pkg::PH_WACK;
                    end
                  end
                  i2cbm_pkg::PH_WDATA: begin
                    if (bit_count != 3'd0) begin
                      bit_count_next = bit_count - 3'd1;
                    end else begin
                      tx_position_next  = tx_position + 5'd1;
                      tx_remaining_next = tx_remaining - 5'd1;
                      phase_next        = i2cbm_pkg::PH_RACK;
                    end
                  end
                  i2cbm_pkg::PH_STOP: begin
                    phase_next = i2cbm_pkg::PH_IDLE;
                    done       = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    store_wr.en      = store_wr.en && go;
    res.scl_pull_low = scl_drive_next;
    res.sda_pull_low = sda_drive_next;
    res.rx_valid     = rx_valid;
    res.rx_data      = rx_valid ? shift_byte : 8'd0;
    res.busy_res     = (phase_next != i2cbm_pkg::PH_IDLE);
    res.ack_error    = error_flag_next;
    res.done_res     = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cbm_pkg::PH_IDLE;
      sub_tick      <= i2cbm_pkg::ST_SET_SDA;
      bit_count     <= 3'd0;
      shift_byte    <= 8'd0;
      target_addr   <= 7'd0;
      addr_read_bit <= 1'b0;
      tx_remaining  <= 5'd0;
      tx_position   <= 5'd0;
      rx_remaining  <= 8'd0;
      stretch_seen  <= 1'b0;
      ack_sample    <= 1'b1;
      error_flag    <= 1'b0;
      scl_drive     <= 1'b0;
      sda_drive     <= 1'b0;
    end else if (go) begin
      phase         <= phase_next;
      sub_tick      <= sub_tick_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      target_addr   <= target_addr_next;
      addr_read_bit <= addr_read_bit_next;
      tx_remaining  <= tx_remaining_next;
      tx_position   <= tx_position_next;
      rx_remaining  <= rx_remaining_next;
      stretch_seen  <= stretch_seen_next;
      ack_sample    <= ack_sample_next;
      error_flag    <= error_flag_next;
      scl_drive     <= scl_drive_next;
      sda_drive     <= sda_drive_next;
    end
  end

endmodule

### design/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// bit-level i2c master, paced by tick requests on the input channel
// input channel: one request per transfer (tick with sampled scl/sda,
//   start transaction, or load one byte into the 16-entry transmit store)
// output channel: one result per request, carrying the scl/sda pull-low
//   drives, a received byte with rx_valid, busy, ack error and done
// each bus bit takes four ticks, more while scl is stretched; the host applies scl/sda pulls to the bus
// the input transfer is captured in the input register, then the state update
//   is written to the result register, from which the result transfer goes;
//   throughput one request per cycle while the result side does not stall, set
//   by the single state update between the two registers
// a stalled result holds in the result register; one more request may wait
//   in the input register, after which the input side stalls
// reset: bus released, idle, no error; transmit store contents undefined
//   until loaded
module i2c_bit_level_master (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic       scl_in,
  input  logic       sda_in,
  input  logic [6:0] dev_addr,
  input  logic       read_op,
  input  logic [4:0] tx_len,
  input  logic [7:0] rx_len,
  input  logic [3:0] tx_index,
  input  logic [7:0] tx_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_pull_low,
  output logic       sda_pull_low,
  output logic       rx_valid,
  output logic [7:0] rx_data,
  output logic       busy_res,
  output logic       ack_error,
  output logic       done_res
);

  logic                           in_q_valid;
  i2cbm_pkg::item_t               in_q;
  i2cbm_pkg::result_t             res, res_q;
  i2cbm_pkg::store_wr_t           store_wr;
  logic [i2cbm_pkg::TX_IDX_W-1:0] store_raddr;
  logic [7:0]                     store_rdata;
  logic                           go;
  logic                           in_take;

  assign go       = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (go) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= '{req_type, scl_in, sda_in, dev_addr, read_op, tx_len, rx_len,
                tx_index, tx_data};
    end
  end

  i2cbm_tx_store #(
    .WIDTH (8),
    .DEPTH (i2cbm_pkg::TX_DEPTH)
  ) u_tx_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  i2cbm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .item        (in_q),
    .store_rdata (store_rdata),
    .store_raddr (store_raddr),
    .store_wr    (store_wr),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign scl_pull_low = res_q.scl_pull_low;
  assign sda_pull_low = res_q.sda_pull_low;
  assign rx_valid     = res_q.rx_valid;
  assign rx_data      = res_q.rx_data;
  assign busy_res     = res_q.busy_res;
  assign ack_error    = res_q.ack_error;
  assign done_res     = res_q.done_res;

endmodule

### design/i2cbm_checker.sv
`timescale 1ns / 1ps

module i2cbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       scl_pull_low,
  input logic       sda_pull_low,
  input logic       rx_valid,
  input logic [7:0] rx_data,
  input logic       busy_res,
  input logic       ack_error,
  input logic       done_res
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rx_data) && $stable(rx_valid)
      && $stable(done_res) && $stable(busy_res))
    else $error("stalled result changed");

  // a completed byte leaves the master waiting to send its ack, with no error
  a_rx_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> busy_res && !done_res && !ack_error)
    else $error("received byte outside a transaction");

  // done means back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !rx_valid)
    else $error("done while still busy");

  // idle master releases the bus
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !scl_pull_low && !sda_pull_low && rx_data == 8'd0)
    else $error("bus held while idle");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .scl_pull_low (scl_pull_low),
  .sda_pull_low (sda_pull_low),
  .rx_valid     (rx_valid),
  .rx_data      (rx_data),
  .busy_res     (busy_res),
  .ack_error    (ack_error),
  .done_res     (done_res)
);

### tb/sv/i2cbm_result_check.sv
`timescale 1ns / 1ps

module i2cbm_result_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] req_type,
  input  logic       scl_in,
  input  logic       sda_in,
  input  logic [6:0] dev_addr,
  input  logic       read_op,
  input  logic [4:0] tx_len,
  input  logic [7:0] rx_len,
  input  logic [3:0] tx_index,
  input  logic [7:0] tx_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       scl_pull_low,
  input  logic       sda_pull_low,
  input  logic       rx_valid,
  input  logic [7:0] rx_data,
  input  logic       busy_res,
  input  logic       ack_error,
  input  logic       done_res,
  output int         fails,
  output int         outstanding
);

  import i2cbm_pkg::*;

  phase_t     phase;
  logic [1:0] sub;
  logic [2:0] bcnt;
  logic [7:0] shreg;
  logic [6:0] taddr;
  logic       rdbit;
  logic [4:0] tx_left;
  logic [4:0] tx_pos;
  logic [7:0] rx_left;
  logic [7:0] store [TX_DEPTH];
  logic       stretched;
  logic       ack_in;
  logic       err;
  logic       scl_dr;
  logic       sda_dr;

  result_t bus_result_q [$];

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic step_bus_master(input item_t it, output result_t res);
    logic       got_byte;
    logic       fin;
    logic [7:0] byte_val;
    got_byte = 1'b0;
    fin = 1'b0;
    byte_val = 8'h00;
    case (it.req_type)
      REQ_START: if (phase == PH_IDLE) begin
        taddr = it.dev_addr;
        tx_left = (it.tx_len > TX_DEPTH) ? 5'(TX_DEPTH) : it.tx_len;
        tx_pos = '0;
        rx_left = it.read_op ? it.rx_len : 8'd0;
        rdbit = (rx_left != 0 && tx_left == 0);
        ack_in = 1'b1;
        err = 1'b0;
        stretched = 1'b0;
        sub = ST_SET_SDA;
        phase = PH_START;
      end
      REQ_LOAD: if (phase == PH_IDLE && int'(it.tx_index) < TX_DEPTH) begin
        store[it.tx_index] = it.tx_data;
      end
      REQ_TICK: if (phase != PH_IDLE) begin
        case (sub)
          ST_SET_SDA: begin
            case (phase)
              PH_START, PH_RACK, PH_RDATA: sda_dr = 1'b0;
              PH_ADDR: sda_dr = ~taddr[bcnt];
              PH_RW: sda_dr = ~rdbit;
              PH_WACK: sda_dr = (rx_left != 0);
              PH_WDATA: sda_dr = ~shreg[bcnt];
              PH_STOP: sda_dr = 1'b1;
              default: ;
            endcase
            sub = ST_REL_SCL;
          end
          ST_REL_SCL: begin
            scl_dr = 1'b0;
            sub = ST_SAMPLE;
          end
          ST_SAMPLE: begin
            if (!it.scl_in) begin
              stretched = 1'b1;
            end else begin
              case (phase)
                PH_START: sda_dr = 1'b1;
                PH_RACK: ack_in = it.sda_in;
                PH_RDATA: shreg = shreg | (8'(it.sda_in) << bcnt);
                PH_STOP: sda_dr = 1'b0;
                default: ;
              endcase
            end
            sub = ST_ADVANCE;
          end
          default: begin
            if (stretched) begin
              stretched = 1'b0;
            end else begin
              if (phase != PH_STOP) scl_dr = 1'b1;
              case (phase)
                PH_START: begin
                  bcnt = ADDR_TOP_BIT;
                  phase = PH_ADDR;
                end
                PH_ADDR: if (bcnt != 0) bcnt--; else phase = PH_RW;
                PH_RW: phase = PH_RACK;
                PH_RACK: begin
                  if (ack_in) begin
                    err = 1'b1;
                    phase = PH_STOP;
                  end else if (tx_left != 0) begin
                    bcnt = BYTE_TOP_BIT;
                    shreg = (tx_pos < TX_DEPTH) ? store[tx_pos[3:0]] : 8'h00;
                    phase = PH_WDATA;
                  end else if (rx_left == 0) begin
                    phase = PH_STOP;
                  end else if (!rdbit) begin
                    rdbit = 1'b1;
                    phase = PH_START;
                  end else begin
                    bcnt = BYTE_TOP_BIT;
                    shreg = 8'h00;
                    phase = PH_RDATA;
                  end
                end
                PH_WACK: begin
                  if (rx_left == 0) begin
                    phase = PH_STOP;
                  end else begin
                    bcnt = BYTE_TOP_BIT;
                    shreg = 8'h00;
                    phase = PH_RDATA;
                  end
                end
                PH_RDATA: begin
                  if (bcnt != 0) begin
                    bcnt--;
                  end else begin
                    got_byte = 1'b1;
                    byte_val = shreg;
                    rx_left--;
                    phase = PH_WACK;
                  end
                end
                PH_WDATA: begin
                  if (bcnt != 0) begin
                    bcnt--;
                  end else begin
                    tx_pos++;
                    tx_left--;
                    phase = PH_RACK;
                  end
                end
                PH_STOP: begin
                  phase = PH_IDLE;
                  fin = 1'b1;
                end
                default: ;
              endcase
            end
            sub = ST_SET_SDA;
          end
        endcase
      end
      default: ;
    endcase
    res = {scl_dr, sda_dr, got_byte, byte_val, phase != PH_IDLE, err, fin};
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      phase = PH_IDLE;
      sub = ST_SET_SDA;
      bcnt = '0;
      shreg = '0;
      taddr = '0;
      rdbit = 1'b0;
      tx_left = '0;
      tx_pos = '0;
      rx_left = '0;
      stretched = 1'b0;
      ack_in = 1'b1;
      err = 1'b0;
      scl_dr = 1'b0;
      sda_dr = 1'b0;
      fails = 0;
      bus_result_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {scl_pull_low, sda_pull_low, rx_valid, rx_data, busy_res, ack_error, done_res};
        if (bus_result_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = bus_result_q.pop_front();
          check_field("scl_pull_low", 8'(want.scl_pull_low), 8'(got.scl_pull_low));
          check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got.sda_pull_low));
          check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
          check_field("rx_data", want.rx_data, got.rx_data);
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        end
      end
      if (in_valid && !in_stall) begin
        it = {req_type, scl_in, sda_in, dev_addr, read_op, tx_len, rx_len, tx_index, tx_data};
        step_bus_master(it, want);
        bus_result_q.push_back(want);
      end
    end
    outstanding <= bus_result_q.size();
  end

endmodule

### tb/sv/tb_i2c_bit_level_master.sv
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;

  import i2cbm_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 20000;
  localparam int ITEM_TARGET = 950;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_NONE;
  logic       scl_in = 1'b1;
  logic       sda_in = 1'b1;
  logic [6:0] dev_addr = '0;
  logic       read_op = 1'b0;
  logic [4:0] tx_len = '0;
  logic [7:0] rx_len = '0;
  logic [3:0] tx_index = '0;
  logic [7:0] tx_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic       busy_res;
  logic       ack_error;
  logic       done_res;
  int         fails;
  int         outstanding;

  int snd_idle_pct = 17;
  int rcv_idle_pct = 62;
  bit hold_req = 1'b0;
  int sent_items = 0;

  i2c_bit_level_master i_dut (.*);

  i2cbm_result_check i_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // result side, with one long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  function automatic item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t mk_tick(input logic scl, input logic sda);
    item_t it;
    it = rand_item();
    it.req_type = REQ_TICK;
    it.scl_in = scl;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic item_t mk_start(input logic [6:0] addr, input logic rd,
                                     input logic [4:0] tlen, input logic [7:0] rlen);
    item_t it;
    it = rand_item();
    it.req_type = REQ_START;
    it.dev_addr = addr;
    it.read_op = rd;
    it.tx_len = tlen;
    it.rx_len = rlen;
    return it;
  endfunction

  function automatic item_t mk_load(input logic [3:0] idx, input logic [7:0] data);
    item_t it;
    it = rand_item();
    it.req_type = REQ_LOAD;
    it.tx_index = idx;
    it.tx_data = data;
    return it;
  endfunction

  // requests the block drops while a transaction runs
  function automatic item_t mk_busy_noise();
    item_t it;
    it = rand_item();
    case ($urandom_range(2))
      0: it.req_type = REQ_START;
      1: it.req_type = REQ_LOAD;
      default: it.req_type = REQ_NONE;
    endcase
    return it;
  endfunction

  task automatic xfer(input item_t it);
    if (sent_items < ITEM_TARGET / 3) begin
      snd_idle_pct = 17;
      rcv_idle_pct = 62;
    end else if (sent_items < 2 * ITEM_TARGET / 3) begin
      snd_idle_pct = 62;
      rcv_idle_pct = 17;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    scl_in <= it.scl_in;
    sda_in <= it.sda_in;
    dev_addr <= it.dev_addr;
    read_op <= it.read_op;
    tx_len <= it.tx_len;
    rx_len <= it.rx_len;
    tx_index <= it.tx_index;
    tx_data <= it.tx_data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // one full transaction; tracks the bus bit so ack slots get chosen levels
  task automatic run_txn(input logic [6:0] addr, input logic rd, input logic [4:0] tlen,
                         input logic [7:0] rlen, input int nack_pct, input int stretch_pct,
                         input int noise_pct);
    int ntx;
    int nrx;
    int w_end;
    int rack2;
    int total;
    int bitno;
    int ph;
    int tail;
    bit slow;
    bit scl;
    bit sda;
    bit is_ack;
    ntx = (int'(tlen) > TX_DEPTH) ? TX_DEPTH : int'(tlen);
    nrx = rd ? int'(rlen) : 0;
    w_end = 9 + 9 * ntx;
    rack2 = (ntx > 0 && nrx > 0) ? w_end + 10 : -1;
    // start through the last write ack, optional restart, reads, then stop
    total = w_end + ((rack2 >= 0) ? 10 : 0) + 9 * nrx + 2;
    xfer(mk_start(addr, rd, tlen, rlen));
    bitno = 0;
    ph = 0;
    slow = 1'b0;
    while (bitno < total) begin
      if ($urandom_range(99) < noise_pct) xfer(mk_busy_noise());
      scl = 1'($urandom_range(1));
      sda = 1'($urandom_range(1));
      if (ph == 2) begin
        scl = 1'b1;
        is_ack = (bitno == 9) || (bitno > 9 && bitno <= w_end && (bitno - 9) % 9 == 0) ||
                 (bitno == rack2);
        if ($urandom_range(99) < stretch_pct) begin
          scl = 1'b0;
          slow = 1'b1;
        end else if (is_ack) begin
          sda = ($urandom_range(99) < nack_pct);
          if (sda) total = bitno + 2;
        end
      end
      xfer(mk_tick(scl, sda));
      if (ph == 3) begin
        if (!slow) bitno++;
        slow = 1'b0;
      end
      ph = (ph + 1) % 4;
    end
    tail = int'($urandom_range(2));
    repeat (tail) xfer(mk_tick(1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  initial begin : source
    int i;
    item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle requests, then fill the whole transmit store
    xfer(mk_tick(1'b1, 1'b0));
    it = rand_item();
    it.req_type = REQ_NONE;
    xfer(it);
    for (i = 0; i < TX_DEPTH; i++) begin
      xfer(mk_load(4'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom)));
    end

    // oversized write length under a long result hold-off
    hold_req = 1'b1;
    run_txn(7'h7F, 1'b0, 5'd31, 8'hFF, 0, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    run_txn(7'h55, 1'b1, 5'd1, 8'd1, 0, 10, 8);
    run_txn(7'h00, 1'b1, 5'd0, 8'd1, 0, 10, 0);
    run_txn(7'h2A, 1'b1, 5'd0, 8'd0, 0, 0, 0);
    run_txn(7'h4C, 1'b1, 5'd2, 8'd3, 100, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
